>>> src/sbm_pkg.sv
// Shared types and constants for the serial bank mapper.
// Request and response payloads, register state and configuration structs.
// No dependencies.
`default_nettype none

package sbm_pkg;

  localparam logic [4:0] CTRL_RESET   = 5'h0C;
  localparam logic [4:0] CTRL_RST_OR  = 5'h0C;
  localparam logic [2:0] SHIFT_LAST   = 3'd4;
  localparam logic [2:0] MIRROR_FOUR  = 3'd4;

  typedef enum logic [2:0] {
    CFG_VARIANT_A       = 3'd0,
    CFG_BOARD_FIXED_PRG = 3'd1,
    CFG_CHR_PRESENT     = 3'd2,
    CFG_PRG_RAM_BANKS   = 3'd3,
    CFG_FOUR_SCREEN     = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    WIN_CONTROL  = 2'd0,
    WIN_CHR_LOW  = 2'd1,
    WIN_CHR_HIGH = 2'd2,
    WIN_PRG      = 2'd3
  } window_t;

  typedef struct packed {
    logic [1:0] address_window;
    logic [7:0] data_byte;
    logic       double_write_second;
  } req_t;

  typedef struct packed {
    logic [4:0] prg_bank_low;
    logic [4:0] prg_bank_high;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [2:0] mirroring_mode;
    logic       prg_ram_enable;
    logic [1:0] prg_ram_bank;
    logic       register_committed;
  } rsp_t;

  typedef struct packed {
    logic [2:0] shift_count;
    logic [4:0] shift_value;
    logic [4:0] control_reg;
    logic [4:0] chr_reg_low;
    logic [4:0] chr_reg_high;
    logic [4:0] prg_reg;
    logic       just_reset;
  } state_t;

  typedef struct packed {
    logic       variant_a;
    logic       board_fixed_prg;
    logic       chr_present;
    logic [2:0] prg_ram_banks;
    logic       four_screen;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/sbm_serial.sv
// Serial load engine: shift register, reset-write handling and the four bank registers.
// Gives the post-write register state combinationally for the decoder.
// Depends on sbm_pkg.
`default_nettype none

module sbm_serial (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire sbm_pkg::req_t req,
  output sbm_pkg::state_t    state,
  output sbm_pkg::state_t    state_next,
  output logic               committed
);

  logic       ignore;
  logic [4:0] shifted;

  assign ignore  = state.just_reset && req.double_write_second;
  assign shifted = state.shift_value | (5'(req.data_byte[0]) << state.shift_count);

  always_comb begin
    state_next            = state;
    committed             = 1'b0;
    state_next.just_reset = 1'b0;
    if (!ignore) begin
      if (req.data_byte[7]) begin
        state_next.just_reset  = 1'b1;
        state_next.shift_count = '0;
        state_next.shift_value = '0;
        state_next.control_reg = state.control_reg | sbm_pkg::CTRL_RST_OR;
      end else if (state.shift_count >= sbm_pkg::SHIFT_LAST) begin
        unique case (sbm_pkg::window_t'(req.address_window))
          sbm_pkg::WIN_CONTROL:  state_next.control_reg  = shifted;
          sbm_pkg::WIN_CHR_LOW:  state_next.chr_reg_low  = shifted;
          sbm_pkg::WIN_CHR_HIGH: state_next.chr_reg_high = shifted;
          sbm_pkg::WIN_PRG:      state_next.prg_reg      = shifted;
          default:               state_next.prg_reg      = shifted;
        endcase
        state_next.shift_count = '0;
        state_next.shift_value = '0;
        committed              = 1'b1;
      end else begin
        state_next.shift_value = shifted;
        state_next.shift_count = state.shift_count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{shift_count: 3'd0, shift_value: 5'd0, control_reg: sbm_pkg::CTRL_RESET,
                 chr_reg_low: 5'd0, chr_reg_high: 5'd0, prg_reg: 5'd0, just_reset: 1'b0};
    end else if (accept) begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> src/sbm_decode.sv
// Bank decoder: PRG/CHR banks, mirroring and PRG-RAM bank from the register state.
// Purely combinational; depends on sbm_pkg.
`default_nettype none

module sbm_decode (
  input  wire sbm_pkg::state_t st,
  input  wire sbm_pkg::cfg_t   cfg,
  input  wire logic            committed,
  output sbm_pkg::rsp_t        rsp
);

  logic [4:0] chr_lo;
  logic [4:0] chr_hi;
  logic [3:0] prg_lo_raw;
  logic [3:0] prg_hi_raw;
  logic       outer_a;
  logic [3:0] prg_lo;
  logic [3:0] prg_hi;
  logic [1:0] ram_bank;

  always_comb begin
    if (st.control_reg[4]) begin
      chr_lo = st.chr_reg_low;
      chr_hi = st.chr_reg_high;
    end else begin
      chr_lo = {st.chr_reg_low[4:1], 1'b0};
      chr_hi = {st.chr_reg_low[4:1], 1'b1};
    end
  end

  always_comb begin
    if (st.control_reg[3]) begin
      if (st.control_reg[2]) begin
        prg_lo_raw = st.prg_reg[3:0];
        prg_hi_raw = 4'hF;
      end else begin
        prg_lo_raw = 4'h0;
        prg_hi_raw = st.prg_reg[3:0];
      end
    end else begin
      prg_lo_raw = {st.prg_reg[3:1], 1'b0};
      prg_hi_raw = {st.prg_reg[3:1], 1'b1};
    end
  end

  // variant A 256K rule: with PRG register bit 4 set, register bit 3 overrides the bank's top bit
  assign outer_a = st.prg_reg[4] && cfg.variant_a;
  assign prg_lo  = {outer_a ? st.prg_reg[3] : prg_lo_raw[3], prg_lo_raw[2:0]};
  assign prg_hi  = {outer_a ? st.prg_reg[3] : prg_hi_raw[3], prg_hi_raw[2:0]};

  always_comb begin
    priority if (cfg.prg_ram_banks == 3'd0 || cfg.prg_ram_banks == 3'd1) begin
      ram_bank = 2'd0;
    end else if (cfg.prg_ram_banks <= 3'd3) begin
      ram_bank = {1'b0, cfg.chr_present ? ~chr_lo[4] : ~chr_lo[3]};
    end else begin
      ram_bank = chr_lo[3:2];
    end
  end

  always_comb begin
    rsp.prg_bank_low       = cfg.board_fixed_prg ? 5'd0 : {chr_lo[4], prg_lo};
    rsp.prg_bank_high      = cfg.board_fixed_prg ? 5'd1 : {chr_lo[4], prg_hi};
    rsp.chr_bank_low       = chr_lo;
    rsp.chr_bank_high      = chr_hi;
    rsp.mirroring_mode     = cfg.four_screen ? sbm_pkg::MIRROR_FOUR
                                             : {1'b0, st.control_reg[1:0]};
    rsp.prg_ram_enable     = cfg.variant_a || !st.prg_reg[4];
    rsp.prg_ram_bank       = ram_bank;
    rsp.register_committed = committed;
  end

endmodule

`default_nettype wire

>>> src/serial_bank_mapper_core.sv
// Top level of the serial bank mapper: configuration registers, serial engine,
// decoder and response register. Depends on sbm_pkg, sbm_serial and sbm_decode.
`default_nettype none

// Each accepted CPU write request yields exactly one response in the next cycle,
// carrying the mapping as it stands after that write. A request is taken every
// cycle; the only hold-off is the single response register, so req_stall is high
// only while a response is waiting and rsp_stall is high. Throughput is one
// request per cycle while req_stall is low. Configuration writes via cfg_we/cfg_index/
// cfg_data take effect on the next request and should be made only when idle.
module serial_bank_mapper_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire sbm_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output sbm_pkg::rsp_t      rsp,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [2:0]    cfg_data
);

  sbm_pkg::cfg_t   cfg;
  sbm_pkg::state_t state;
  sbm_pkg::state_t state_next;
  sbm_pkg::rsp_t   rsp_next;
  logic            committed;
  logic            accept;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.variant_a       <= 1'b0;
      cfg.board_fixed_prg <= 1'b0;
      cfg.chr_present     <= 1'b1;
      cfg.prg_ram_banks   <= 3'd1;
      cfg.four_screen     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbm_pkg::CFG_VARIANT_A:       cfg.variant_a       <= cfg_data[0];
        sbm_pkg::CFG_BOARD_FIXED_PRG: cfg.board_fixed_prg <= cfg_data[0];
        sbm_pkg::CFG_CHR_PRESENT:     cfg.chr_present     <= cfg_data[0];
        sbm_pkg::CFG_PRG_RAM_BANKS:   cfg.prg_ram_banks   <= cfg_data;
        sbm_pkg::CFG_FOUR_SCREEN:     cfg.four_screen     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sbm_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req        (req),
    .state      (state),
    .state_next (state_next),
    .committed  (committed)
  );

  sbm_decode u_decode (
    .st        (state_next),
    .cfg       (cfg),
    .committed (committed),
    .rsp       (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_accept_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request produced no response");

  a_commit_clears_shift: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.register_committed) |-> (state.shift_count == 3'd0))
    else $error("commit left the shift counter running");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    state.shift_count <= sbm_pkg::SHIFT_LAST)
    else $error("shift counter out of range");

  a_reset_write_clears: assert property (@(posedge clk) disable iff (rst)
    state.just_reset |-> (state.shift_count == 3'd0 && state.shift_value == 5'd0))
    else $error("reset write did not clear the shift register");

endmodule

`default_nettype wire
